/* design/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// shared widths, defaults and controller/datapath handshake types for the
// greedy box non-maximum suppression block
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 15;
    localparam int AREA_W    = 30;
    localparam int THR_W     = 9;
    localparam int INDEX_W   = 12;

    localparam int MAX_KEPT_DEF  = 64;
    localparam int MAX_BOXES_DEF = 4096;

    localparam logic [THR_W-1:0] THR_RESET = 9'd102;

    // one stored kept box
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [AREA_W-1:0]         area;
    } kept_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } gbn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic pipe_busy;
        logic out_free;
    } gbn_stat_t;

endpackage

/* design/gbn_if.sv */
// ----------------------------------------------------------------------------
// gbn_if
// valid/ready channels for incoming boxes and outgoing results
// ----------------------------------------------------------------------------
interface gbn_box_if;
    import gbn_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [SIZE_W-1:0]         box_w;
    logic [SIZE_W-1:0]         box_h;
    logic                      last_box;

    modport source (output valid, box_x, box_y, box_w, box_h, last_box, input ready);
    modport sink   (input valid, box_x, box_y, box_w, box_h, last_box, output ready);
endinterface

interface gbn_res_if;
    import gbn_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] box_index;
    logic               kept;
    logic               overflow;
    logic               last_result;

    modport source (output valid, box_index, kept, overflow, last_result, input ready);
    modport sink   (input valid, box_index, kept, overflow, last_result, output ready);
endinterface

/* design/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// gbn_ctrl
// sequencer: take a box, scan the kept store, drain the compare pipeline,
// then post the result
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbn_pkg::gbn_stat_t stat,
    output gbn_pkg::gbn_cmd_t  cmd
);
    import gbn_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/gbn_dp.sv */
// ----------------------------------------------------------------------------
// gbn_dp
// box register, kept-box memory, pipelined iou compare, counters and
// result register
// ----------------------------------------------------------------------------
module gbn_dp #(
    parameter int MAX_KEPT  = gbn_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = gbn_pkg::MAX_BOXES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gbn_pkg::gbn_cmd_t                 cmd,
    output gbn_pkg::gbn_stat_t                stat,
    input  logic                              cfg_we,
    input  logic [gbn_pkg::THR_W-1:0]         cfg_data,
    input  logic signed [gbn_pkg::COORD_W-1:0] in_x,
    input  logic signed [gbn_pkg::COORD_W-1:0] in_y,
    input  logic [gbn_pkg::SIZE_W-1:0]        in_w,
    input  logic [gbn_pkg::SIZE_W-1:0]        in_h,
    input  logic                              in_last,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [gbn_pkg::INDEX_W-1:0]       res_index,
    output logic                              res_kept,
    output logic                              res_overflow,
    output logic                              res_last
);
    import gbn_pkg::*;

    localparam int KW   = $clog2(MAX_KEPT + 1);
    localparam int AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int BW   = $clog2(MAX_BOXES);
    localparam int UW   = AREA_W + 1;
    localparam int LW   = AREA_W + 8;
    localparam int PW   = UW + THR_W;

    function automatic logic [SIZE_W-1:0] ovl(
        input logic signed [COORD_W-1:0] a0,
        input logic [SIZE_W-1:0]         al,
        input logic signed [COORD_W-1:0] b0,
        input logic [SIZE_W-1:0]         bl
    );
        logic signed [COORD_W+1:0] as, ae, bs, be, lo, hi, d;
        as = (COORD_W+2)'(a0);
        bs = (COORD_W+2)'(b0);
        ae = as + $signed({3'b000, al});
        be = bs + $signed({3'b000, bl});
        lo = (as > bs) ? as : bs;
        hi = (ae < be) ? ae : be;
        d  = hi - lo;
        ovl = (d > 0) ? d[SIZE_W-1:0] : '0;
    endfunction

    // configuration and current box
    logic [THR_W-1:0]          thr_reg;
    logic signed [COORD_W-1:0] bx_reg, by_reg;
    logic [SIZE_W-1:0]         bw_reg, bh_reg;
    logic                      last_reg;
    logic [AREA_W-1:0]         area_reg;

    // counters
    logic [KW-1:0]             kept_cnt_reg;
    logic [KW-1:0]             scan_idx_reg;
    logic [BW-1:0]             box_cnt_reg;

    // memory and compare pipeline
    kept_entry_t               mem [MAX_KEPT];
    kept_entry_t               rd_q;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SIZE_W-1:0]         iw_reg, ih_reg;
    logic [AREA_W-1:0]         ka2_reg, ka3_reg;
    logic [AREA_W-1:0]         inter3_reg, inter4_reg;
    logic [UW-1:0]             uni4_reg;
    logic [LW-1:0]             lhs5_reg;
    logic [PW-1:0]             rhs5_reg;
    logic                      supp_reg;

    // result register
    logic                      res_valid_reg;
    logic [INDEX_W-1:0]        res_index_reg;
    logic                      res_kept_reg, res_ovf_reg, res_last_reg;

    logic                      full;
    logic                      store;
    kept_entry_t               wr_entry;

    assign full  = (kept_cnt_reg == KW'(MAX_KEPT));
    assign store = cmd.finish && !supp_reg && !full;

    assign wr_entry.left   = bx_reg;
    assign wr_entry.top    = by_reg;
    assign wr_entry.width  = bw_reg;
    assign wr_entry.height = bh_reg;
    assign wr_entry.area   = area_reg;

    assign stat.scan_end  = (scan_idx_reg == kept_cnt_reg);
    assign stat.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign stat.out_free  = !res_valid_reg || res_ready;

    assign res_valid    = res_valid_reg;
    assign res_index    = res_index_reg;
    assign res_kept     = res_kept_reg;
    assign res_overflow = res_ovf_reg;
    assign res_last     = res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // box capture and area
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bx_reg   <= in_x;
            by_reg   <= in_y;
            bw_reg   <= in_w;
            bh_reg   <= in_h;
            last_reg <= in_last;
        end
        area_reg <= AREA_W'(bw_reg) * AREA_W'(bh_reg);
    end

    // kept store
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[kept_cnt_reg[AW-1:0]] <= wr_entry;
        end
        rd_q <= mem[scan_idx_reg[AW-1:0]];
    end

    // compare pipeline payload
    always_ff @(posedge clk)
    begin
        iw_reg     <= ovl(bx_reg, bw_reg, rd_q.left, rd_q.width);
        ih_reg     <= ovl(by_reg, bh_reg, rd_q.top, rd_q.height);
        ka2_reg    <= rd_q.area;
        inter3_reg <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        ka3_reg    <= ka2_reg;
        uni4_reg   <= UW'({1'b0, area_reg}) + UW'({1'b0, ka3_reg})
                      - UW'({1'b0, inter3_reg});
        inter4_reg <= inter3_reg;
        lhs5_reg   <= {inter4_reg, 8'b0};
        rhs5_reg   <= PW'(thr_reg) * PW'(uni4_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            supp_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            kept_cnt_reg  <= '0;
            box_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;

            if (cmd.load)
            begin
                supp_reg     <= 1'b0;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (v5_reg && (PW'(lhs5_reg) > rhs5_reg))
                begin
                    supp_reg <= 1'b1;
                end
                if (cmd.issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end

            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    kept_cnt_reg <= '0;
                    box_cnt_reg  <= '0;
                end
                else
                begin
                    if (store)
                    begin
                        kept_cnt_reg <= kept_cnt_reg + 1'b1;
                    end
                    if (box_cnt_reg == BW'(MAX_BOXES - 1))
                    begin
                        box_cnt_reg <= '0;
                    end
                    else
                    begin
                        box_cnt_reg <= box_cnt_reg + 1'b1;
                    end
                end
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_index_reg <= INDEX_W'(box_cnt_reg);
            res_kept_reg  <= !supp_reg;
            res_ovf_reg   <= !supp_reg && full;
            res_last_reg  <= last_reg;
        end
    end

endmodule

/* design/greedy_box_nms.sv */
// ----------------------------------------------------------------------------
// greedy_box_nms
// greedy non-maximum suppression by iou over a score-sorted box stream
// ----------------------------------------------------------------------------
// usage:
//   box_in carries one detection box per transfer (Q12.4 corner, size and a
//   last_box flag closing the frame); res_out returns exactly one result per
//   box, in order: its index in the frame, kept, overflow and last_result.
//   cfg_we/cfg_data write the 9-bit iou threshold (1/256 units) while idle.
// sequencing:
//   one box at a time; the time from transfer in to result posted grows with K,
//   the number of boxes kept so far in the frame (at most MAX_KEPT). it is set
//   by the scan of the kept-box memory, one entry per cycle through its single
//   read port, plus the five-stage compare pipeline drain; the next box can be
//   taken in the cycle after the result is posted.
// reset:
//   kept count and box index return to zero, threshold returns to 102; the
//   kept-box memory is not cleared, only entries below the count are read.
// stall:
//   the result sits in an output register; a new box is taken while it
//   waits, and the next result is held back until the current one transfers.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
    parameter int MAX_KEPT  = gbn_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = gbn_pkg::MAX_BOXES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [gbn_pkg::THR_W-1:0] cfg_data,
    gbn_box_if.sink                   box_in,
    gbn_res_if.source                 res_out
);
    import gbn_pkg::*;

    gbn_cmd_t  cmd;
    gbn_stat_t stat;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (box_in.valid),
        .in_ready (box_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbn_dp #(
        .MAX_KEPT  (MAX_KEPT),
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_x         (box_in.box_x),
        .in_y         (box_in.box_y),
        .in_w         (box_in.box_w),
        .in_h         (box_in.box_h),
        .in_last      (box_in.last_box),
        .res_valid    (res_out.valid),
        .res_ready    (res_out.ready),
        .res_index    (res_out.box_index),
        .res_kept     (res_out.kept),
        .res_overflow (res_out.overflow),
        .res_last     (res_out.last_result)
    );

endmodule
